>>> src/udw_pkg.sv
// ----------------------------------------------------------------------------
// udw_pkg
// Types, constants and tables for the utf-8 decoder with display width.
// ----------------------------------------------------------------------------
package udw_pkg;

  localparam int CP_W = 21;
  localparam int RANGE_W = 2 * CP_W;
  localparam int ROM_IDX_W = 11;

  localparam logic [CP_W-1:0] PAD_VALUE = 21'h1fffff;
  localparam logic [CP_W-1:0] CP_WIDE_MIN = 21'h000300;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00d800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00dfff;
  localparam logic [CP_W-1:0] CP_MAX = 21'h10ffff;

  localparam logic [2:0] W_ZERO = 3'd0;
  localparam logic [2:0] W_ONE = 3'd1;
  localparam logic [2:0] W_TWO = 3'd2;
  localparam logic [2:0] W_BAD_LEAD = 3'd4;

  typedef enum logic [1:0] {
    T_IDLE,
    T_SEARCH,
    T_EMIT
  } top_state_t;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_READ,
    SR_CMP
  } search_state_t;

  typedef struct packed {
    logic done;
    logic found;
  } search_status_t;

  function automatic logic zero_width(input logic [CP_W-1:0] cp);
    return (cp >= 21'h0300 && cp <= 21'h036f) || (cp >= 21'h0483 && cp <= 21'h0489)
        || (cp >= 21'h0591 && cp <= 21'h05bd) || (cp >= 21'h0610 && cp <= 21'h061a)
        || (cp >= 21'h064b && cp <= 21'h065f) || (cp >= 21'h0e31 && cp <= 21'h0e3a)
        || (cp >= 21'h1ab0 && cp <= 21'h1aff) || (cp >= 21'h1dc0 && cp <= 21'h1dff)
        || (cp >= 21'h20d0 && cp <= 21'h20f0) || (cp >= 21'hfe00 && cp <= 21'hfe0f)
        || (cp >= 21'hfe20 && cp <= 21'hfe2f)
        || (cp >= 21'h200b && cp <= 21'h200d) || cp == 21'hfeff
        || (cp >= 21'he0100 && cp <= 21'he01ef);
  endfunction

  function automatic logic [RANGE_W-1:0] rg(input logic [CP_W-1:0] a,
                                            input logic [CP_W-1:0] b);
    return {a, b};
  endfunction

  // sorted wide / ambiguous ranges, first and last
  function automatic logic [RANGE_W-1:0] dw_range(input logic [ROM_IDX_W-1:0] idx);
    logic [RANGE_W-1:0] r;
    case (idx)
      11'd0: r = rg('h0391,'h03a1); 11'd1: r = rg('h03a3,'h03a9); 11'd2: r = rg('h03b1,'h03c1);
      11'd3: r = rg('h03c3,'h03c9); 11'd4: r = rg('h0401,'h0401); 11'd5: r = rg('h0410,'h044f);
      11'd6: r = rg('h0451,'h0451); 11'd7: r = rg('h1100,'h115f); 11'd8: r = rg('h2010,'h2010);
      11'd9: r = rg('h2013,'h2016); 11'd10: r = rg('h2018,'h2019); 11'd11: r = rg('h201c,'h201d);
      11'd12: r = rg('h2020,'h2022); 11'd13: r = rg('h2024,'h2027); 11'd14: r = rg('h2030,'h2030);
      11'd15: r = rg('h2032,'h2033); 11'd16: r = rg('h2035,'h2035); 11'd17: r = rg('h203b,'h203b);
      11'd18: r = rg('h203e,'h203e); 11'd19: r = rg('h2074,'h2074); 11'd20: r = rg('h207f,'h207f);
      11'd21: r = rg('h2081,'h2084); 11'd22: r = rg('h20ac,'h20ac); 11'd23: r = rg('h2103,'h2103);
      11'd24: r = rg('h2105,'h2105); 11'd25: r = rg('h2109,'h2109); 11'd26: r = rg('h2113,'h2113);
      11'd27: r = rg('h2116,'h2116); 11'd28: r = rg('h2121,'h2122); 11'd29: r = rg('h2126,'h2126);
      11'd30: r = rg('h212b,'h212b); 11'd31: r = rg('h2153,'h2154); 11'd32: r = rg('h215b,'h215e);
      11'd33: r = rg('h2160,'h216b); 11'd34: r = rg('h2170,'h2179); 11'd35: r = rg('h2189,'h2189);
      11'd36: r = rg('h2190,'h2199); 11'd37: r = rg('h21b8,'h21b9); 11'd38: r = rg('h21d2,'h21d2);
      11'd39: r = rg('h21d4,'h21d4); 11'd40: r = rg('h21e7,'h21e7); 11'd41: r = rg('h2200,'h2200);
      11'd42: r = rg('h2202,'h2203); 11'd43: r = rg('h2207,'h2208); 11'd44: r = rg('h220b,'h220b);
      11'd45: r = rg('h220f,'h220f); 11'd46: r = rg('h2211,'h2211); 11'd47: r = rg('h2215,'h2215);
      11'd48: r = rg('h221a,'h221a); 11'd49: r = rg('h221d,'h2220); 11'd50: r = rg('h2223,'h2223);
      11'd51: r = rg('h2225,'h2225); 11'd52: r = rg('h2227,'h222c); 11'd53: r = rg('h222e,'h222e);
      11'd54: r = rg('h2234,'h2237); 11'd55: r = rg('h223c,'h223d); 11'd56: r = rg('h2248,'h2248);
      11'd57: r = rg('h224c,'h224c); 11'd58: r = rg('h2252,'h2252); 11'd59: r = rg('h2260,'h2261);
      11'd60: r = rg('h2264,'h2267); 11'd61: r = rg('h226a,'h226b); 11'd62: r = rg('h226e,'h226f);
      11'd63: r = rg('h2282,'h2283); 11'd64: r = rg('h2286,'h2287); 11'd65: r = rg('h2295,'h2295);
      11'd66: r = rg('h2299,'h2299); 11'd67: r = rg('h22a5,'h22a5); 11'd68: r = rg('h22bf,'h22bf);
      11'd69: r = rg('h2312,'h2312); 11'd70: r = rg('h231a,'h231b); 11'd71: r = rg('h2329,'h232a);
      11'd72: r = rg('h23e9,'h23ec); 11'd73: r = rg('h23f0,'h23f0); 11'd74: r = rg('h23f3,'h23f3);
      11'd75: r = rg('h2460,'h24e9); 11'd76: r = rg('h24eb,'h254b); 11'd77: r = rg('h2550,'h2573);
      11'd78: r = rg('h2580,'h258f); 11'd79: r = rg('h2592,'h2595); 11'd80: r = rg('h25a0,'h25a1);
      11'd81: r = rg('h25a3,'h25a9); 11'd82: r = rg('h25b2,'h25b3); 11'd83: r = rg('h25b6,'h25b7);
      11'd84: r = rg('h25bc,'h25bd); 11'd85: r = rg('h25c0,'h25c1); 11'd86: r = rg('h25c6,'h25c8);
      11'd87: r = rg('h25cb,'h25cb); 11'd88: r = rg('h25ce,'h25d1); 11'd89: r = rg('h25e2,'h25e5);
      11'd90: r = rg('h25ef,'h25ef); 11'd91: r = rg('h25fd,'h25fe); 11'd92: r = rg('h2605,'h2606);
      11'd93: r = rg('h2609,'h2609); 11'd94: r = rg('h260e,'h260f); 11'd95: r = rg('h2614,'h2615);
      11'd96: r = rg('h261c,'h261c); 11'd97: r = rg('h261e,'h261e); 11'd98: r = rg('h2640,'h2640);
      11'd99: r = rg('h2642,'h2642); 11'd100: r = rg('h2648,'h2653); 11'd101: r = rg('h2660,'h2661);
      11'd102: r = rg('h2663,'h2665); 11'd103: r = rg('h2667,'h266a); 11'd104: r = rg('h266c,'h266d);
      11'd105: r = rg('h266f,'h266f); 11'd106: r = rg('h267f,'h267f); 11'd107: r = rg('h2693,'h2693);
      11'd108: r = rg('h269e,'h269f); 11'd109: r = rg('h26a1,'h26a1); 11'd110: r = rg('h26aa,'h26ab);
      11'd111: r = rg('h26bd,'h26be); 11'd112: r = rg('h26bf,'h26bf); 11'd113: r = rg('h26c4,'h26c5);
      11'd114: r = rg('h26c6,'h26cd); 11'd115: r = rg('h26ce,'h26ce); 11'd116: r = rg('h26cf,'h26d3);
      11'd117: r = rg('h26d4,'h26d4); 11'd118: r = rg('h26d5,'h26e1); 11'd119: r = rg('h26e3,'h26e3);
      11'd120: r = rg('h26e8,'h26e9); 11'd121: r = rg('h26ea,'h26ea); 11'd122: r = rg('h26eb,'h26f1);
      11'd123: r = rg('h26f2,'h26f3); 11'd124: r = rg('h26f4,'h26f4); 11'd125: r = rg('h26f5,'h26f5);
      11'd126: r = rg('h26f6,'h26f9); 11'd127: r = rg('h26fa,'h26fa); 11'd128: r = rg('h26fb,'h26fc);
      11'd129: r = rg('h26fd,'h26fd); 11'd130: r = rg('h26fe,'h26ff); 11'd131: r = rg('h2705,'h2705);
      11'd132: r = rg('h270a,'h270b); 11'd133: r = rg('h2728,'h2728); 11'd134: r = rg('h273d,'h273d);
      11'd135: r = rg('h274c,'h274c); 11'd136: r = rg('h274e,'h274e); 11'd137: r = rg('h2753,'h2755);
      11'd138: r = rg('h2757,'h2757); 11'd139: r = rg('h2776,'h277f); 11'd140: r = rg('h2795,'h2797);
      11'd141: r = rg('h27b0,'h27b0); 11'd142: r = rg('h27bf,'h27bf); 11'd143: r = rg('h2b1b,'h2b1c);
      11'd144: r = rg('h2b50,'h2b50); 11'd145: r = rg('h2b55,'h2b55); 11'd146: r = rg('h2b56,'h2b59);
      11'd147: r = rg('h2e80,'h303e); 11'd148: r = rg('h3041,'h33ff); 11'd149: r = rg('h3400,'h4dbf);
      11'd150: r = rg('h4e00,'ha4cf); 11'd151: r = rg('ha960,'ha97f); 11'd152: r = rg('hac00,'hd7a3);
      11'd153: r = rg('he000,'hf8ff); 11'd154: r = rg('hf900,'hfaff); 11'd155: r = rg('hfe10,'hfe19);
      11'd156: r = rg('hfe30,'hfe6f); 11'd157: r = rg('hff00,'hff60); 11'd158: r = rg('hffe0,'hffe6);
      11'd159: r = rg('hfffd,'hfffd); 11'd160: r = rg('h16fe0,'h16fe4);
      11'd161: r = rg('h16ff0,'h16ff1); 11'd162: r = rg('h17000,'h18d08);
      11'd163: r = rg('h1aff0,'h1b16f); 11'd164: r = rg('h1f004,'h1f004);
      11'd165: r = rg('h1f0cf,'h1f0cf); 11'd166: r = rg('h1f18e,'h1f18e);
      11'd167: r = rg('h1f191,'h1f19a); 11'd168: r = rg('h1f200,'h1f320);
      11'd169: r = rg('h1f32d,'h1f335); 11'd170: r = rg('h1f337,'h1f37c);
      11'd171: r = rg('h1f37e,'h1f393); 11'd172: r = rg('h1f3a0,'h1f3ca);
      11'd173: r = rg('h1f3cf,'h1f3d3); 11'd174: r = rg('h1f3e0,'h1f3f0);
      11'd175: r = rg('h1f3f4,'h1f3f4); 11'd176: r = rg('h1f3f8,'h1f43e);
      11'd177: r = rg('h1f440,'h1f440); 11'd178: r = rg('h1f442,'h1f4fc);
      11'd179: r = rg('h1f4ff,'h1f53d); 11'd180: r = rg('h1f54b,'h1f54e);
      11'd181: r = rg('h1f550,'h1f567); 11'd182: r = rg('h1f57a,'h1f57a);
      11'd183: r = rg('h1f595,'h1f596); 11'd184: r = rg('h1f5a4,'h1f5a4);
      11'd185: r = rg('h1f5fb,'h1f64f); 11'd186: r = rg('h1f680,'h1f6c5);
      11'd187: r = rg('h1f6cc,'h1f6cc); 11'd188: r = rg('h1f6d0,'h1f6d2);
      11'd189: r = rg('h1f6d5,'h1f6d7); 11'd190: r = rg('h1f6dc,'h1f6df);
      11'd191: r = rg('h1f6eb,'h1f6ec); 11'd192: r = rg('h1f6f4,'h1f6fc);
      11'd193: r = rg('h1f7e0,'h1f7f0); 11'd194: r = rg('h1f90c,'h1f93a);
      11'd195: r = rg('h1f93c,'h1f945); 11'd196: r = rg('h1f947,'h1f9ff);
      11'd197: r = rg('h1fa70,'h1faff); 11'd198: r = rg('h20000,'h3fffd);
      11'd199: r = rg('hf0000,'hffffd); 11'd200: r = rg('h100000,'h10fffd);
      default: r = {PAD_VALUE, PAD_VALUE};
    endcase
    return r;
  endfunction

endpackage

>>> src/udw_in_if.sv
// ----------------------------------------------------------------------------
// udw_in_if
// Byte request channel into the decoder.
// ----------------------------------------------------------------------------
interface udw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

>>> src/udw_out_if.sv
// ----------------------------------------------------------------------------
// udw_out_if
// Character result channel out of the decoder.
// ----------------------------------------------------------------------------
interface udw_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  byte_count;
  logic        malformed;
  logic [2:0]  display_width;
  logic        last_of_run;

  modport source (output valid, output code_point, output byte_count, output malformed,
                  output display_width, output last_of_run, input ready);
  modport sink (input valid, input code_point, input byte_count, input malformed,
                input display_width, input last_of_run, output ready);
endinterface

>>> src/udw_rom.sv
// ----------------------------------------------------------------------------
// udw_rom
// Range table memory, one registered read per cycle.
// ----------------------------------------------------------------------------
module udw_rom #(
  parameter int RANGE_ENTRIES = 512
) (
  input  logic                                clk,
  input  logic [$clog2(RANGE_ENTRIES)-1:0]    addr,
  output logic [udw_pkg::RANGE_W-1:0]         rdata
);
  import udw_pkg::*;

  always_ff @(posedge clk) begin
    rdata <= dw_range(ROM_IDX_W'(addr));
  end
endmodule

>>> src/udw_search.sv
// ----------------------------------------------------------------------------
// udw_search
// Binary search of a code point over the range table memory.
// ----------------------------------------------------------------------------
module udw_search #(
  parameter int RANGE_ENTRIES = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [udw_pkg::CP_W-1:0]      cp,
  output udw_pkg::search_status_t       status
);
  import udw_pkg::*;

  localparam int AW = $clog2(RANGE_ENTRIES);

  search_state_t state, state_next;
  logic [AW:0]     lo, hi;
  logic [AW-1:0]   mid;
  logic [AW+1:0]   mid_sum;
  logic [CP_W-1:0] key;
  logic [RANGE_W-1:0] rdata;
  logic [CP_W-1:0] first, last;
  logic            empty, below, above;

  udw_rom #(.RANGE_ENTRIES(RANGE_ENTRIES)) u_rom (
    .clk   (clk),
    .addr  (mid_sum[AW:1]),
    .rdata (rdata)
  );

  assign first   = rdata[RANGE_W-1:CP_W];
  assign last    = rdata[CP_W-1:0];
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign empty   = lo > hi;
  assign below   = key < first;
  assign above   = key > last;

  always_comb begin
    state_next = state;
    unique case (state)
      SR_IDLE: if (start) state_next = SR_READ;
      SR_READ: state_next = empty ? SR_IDLE : SR_CMP;
      SR_CMP: begin
        if (!below && !above) state_next = SR_IDLE;
        else if (below && mid == '0) state_next = SR_IDLE;
        else state_next = SR_READ;
      end
      default: state_next = SR_IDLE;
    endcase
  end

  always_comb begin
    status = '0;
    unique case (state)
      SR_READ: status.done = empty;
      SR_CMP: begin
        status.done  = (!below && !above) || (below && mid == '0);
        status.found = !below && !above;
      end
      default: status = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= SR_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == SR_IDLE && start) begin
      key <= cp;
      lo  <= '0;
      hi  <= (AW+1)'(RANGE_ENTRIES - 1);
    end else if (state == SR_READ) begin
      mid <= mid_sum[AW:1];
    end else if (state == SR_CMP) begin
      if (below) hi <= {1'b0, mid} - 1'b1;
      else if (above) lo <= {1'b0, mid} + 1'b1;
    end
  end
endmodule

>>> src/utf8_decode_display_width.sv
// ----------------------------------------------------------------------------
// utf8_decode_display_width
// UTF-8 byte stream decoder giving code point, length, error flag and width.
// ----------------------------------------------------------------------------
// One byte is taken per request. A byte that completes nothing gives no
// result and the block is ready again on the next cycle. Results leave
// through the output register one at a time, and a byte causing n results
// holds the input until the last of them has been emitted. A completed,
// well-formed character at or above 0x300 that is not zero width goes
// through a binary search of the range memory, each probe a read state and
// a compare state, up to log2(RANGE_ENTRIES)+1 probes.
module utf8_decode_display_width #(
  parameter int RANGE_ENTRIES = 512
) (
  input logic clk,
  input logic rst,
  udw_in_if.sink   din,
  udw_out_if.source dout
);
  import udw_pkg::*;

  top_state_t state, state_next;

  logic [1:0]      held;
  logic [2:0]      exp_len;
  logic [CP_W-1:0] partial;

  logic [2:0]      err_left;
  logic            err_first;
  logic            fin_pending;
  logic [CP_W-1:0] fin_cp;
  logic [2:0]      fin_cnt;
  logic            fin_bad;
  logic [2:0]      fin_w;

  logic            accept, tail, complete, bad_val, lookup, emit_go, emit_err, emit_last;
  logic [7:0]      b;
  logic [CP_W-1:0] pv_next;
  logic [2:0]      d_err;
  logic            d_fin;
  search_status_t  sstat;

  assign accept   = din.valid && din.ready;
  assign b        = din.in_byte;
  assign tail     = b[7:6] == 2'b10;
  assign pv_next  = {partial[CP_W-7:0], b[5:0]};
  assign complete = held != 2'd0 && tail && ({1'b0, held} + 3'd1) >= exp_len;
  assign bad_val  = (exp_len == 3'd2 && pv_next < 21'h80)
                 || (exp_len == 3'd3 && pv_next < 21'h800)
                 || (exp_len == 3'd4 && pv_next < 21'h10000)
                 || (pv_next >= SURR_LO && pv_next <= SURR_HI) || pv_next > CP_MAX
                 || exp_len < 3'd2 || exp_len > 3'd4;
  assign lookup   = complete && !bad_val && pv_next >= CP_WIDE_MIN && !zero_width(pv_next);

  // results caused by the incoming byte
  always_comb begin
    d_err = 3'd0;
    d_fin = 1'b0;
    if (held != 2'd0 && tail) begin
      if (complete) begin
        if (bad_val) d_err = {1'b0, held} + 3'd1;
        else d_fin = 1'b1;
      end
    end else begin
      d_err = {1'b0, held};
      d_fin = b != 8'h00 && !(b >= 8'hc2 && b < 8'hf5);
    end
  end

  assign din.ready = state == T_IDLE;
  assign emit_go   = state == T_EMIT && (!dout.valid || dout.ready);
  assign emit_err  = err_left != 3'd0;
  assign emit_last = emit_err ? (err_left == 3'd1 && !fin_pending) : 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE: begin
        if (accept && lookup) state_next = T_SEARCH;
        else if (accept && (d_err != 3'd0 || d_fin)) state_next = T_EMIT;
      end
      T_SEARCH: if (sstat.done) state_next = T_EMIT;
      T_EMIT: if (emit_go && emit_last) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= T_IDLE;
    else state <= state_next;
  end

  udw_search #(.RANGE_ENTRIES(RANGE_ENTRIES)) u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && lookup),
    .cp     (pv_next),
    .status (sstat)
  );

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= 2'd0;
      exp_len <= 3'd0;
      partial <= '0;
    end else if (accept) begin
      if (held != 2'd0 && tail) begin
        if (complete) begin
          held    <= 2'd0;
          exp_len <= 3'd0;
          partial <= '0;
        end else begin
          held    <= held + 2'd1;
          partial <= pv_next;
        end
      end else if (b >= 8'hc2 && b < 8'hf5) begin
        held <= 2'd1;
        if (b < 8'he0) begin
          exp_len <= 3'd2;
          partial <= CP_W'(b[4:0]);
        end else if (b < 8'hf0) begin
          exp_len <= 3'd3;
          partial <= CP_W'(b[3:0]);
        end else begin
          exp_len <= 3'd4;
          partial <= CP_W'(b[2:0]);
        end
      end else begin
        held    <= 2'd0;
        exp_len <= 3'd0;
        partial <= '0;
      end
    end
  end

  // pending results
  always_ff @(posedge clk) begin
    if (rst) begin
      err_left    <= 3'd0;
      fin_pending <= 1'b0;
    end else if (accept) begin
      err_left    <= d_err;
      fin_pending <= d_fin;
    end else if (emit_go) begin
      if (emit_err) err_left <= err_left - 3'd1;
      else fin_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_first <= 1'b1;
      if (held != 2'd0 && tail) begin
        fin_cp  <= pv_next;
        fin_cnt <= exp_len;
        fin_bad <= 1'b0;
        fin_w   <= (pv_next < CP_WIDE_MIN) ? W_ONE
                 : zero_width(pv_next) ? W_ZERO : W_ONE;
      end else begin
        fin_cnt <= 3'd1;
        if (b < 8'h80) begin
          fin_cp  <= CP_W'(b);
          fin_bad <= 1'b0;
          fin_w   <= W_ONE;
        end else begin
          fin_cp  <= '0;
          fin_bad <= 1'b1;
          fin_w   <= tail ? W_ZERO : W_BAD_LEAD;
        end
      end
    end else begin
      if (state == T_SEARCH && sstat.done) fin_w <= sstat.found ? W_TWO : W_ONE;
      if (emit_go && emit_err) err_first <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) dout.valid <= 1'b0;
    else if (emit_go) dout.valid <= 1'b1;
    else if (dout.ready) dout.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      dout.last_of_run <= emit_last;
      if (emit_err) begin
        dout.code_point    <= '0;
        dout.byte_count    <= 3'd1;
        dout.malformed     <= 1'b1;
        dout.display_width <= err_first ? W_BAD_LEAD : W_ZERO;
      end else begin
        dout.code_point    <= fin_cp;
        dout.byte_count    <= fin_cnt;
        dout.malformed     <= fin_bad;
        dout.display_width <= fin_w;
      end
    end
  end
endmodule
